>>> rtl/core/seven_segment_scan_driver_assert.svh
// ----------------------------------------------------------------------------
// seven_segment_scan_driver assertion macros
// concurrent assertion wrappers clocked on clk_i; SSSD_ASSERT is disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// property checked only outside reset
`define SSSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every edge, reset included
`define SSSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg
// shared constants, types and segment lookup for the scan driver
// ----------------------------------------------------------------------------
package sssd_pkg;

  localparam int unsigned NumDigitsDefault = 6;
  localparam int unsigned CodeDigits       = 6;
  localparam int unsigned ValueWidth       = 24;
  localparam int unsigned BinBits          = 20;
  localparam int unsigned StepWidth        = 5;

  localparam logic [ValueWidth-1:0] DecMax    = 24'd999999;
  localparam logic [3:0]            CodeBlank = 4'd10;
  localparam logic [3:0]            CodeMaxDec = 4'd9;
  localparam logic [7:0]            SegBlank  = 8'hFF;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic bcd_mode;
  } status_t;

  // active-low segment patterns, codes above 9 blank
  function automatic logic [7:0] seg_lut(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage

>>> rtl/core/sssd_datapath.sv
// ----------------------------------------------------------------------------
// sssd_datapath
// value cache, shift-add-3 converter, digit code store, scan output register
// ----------------------------------------------------------------------------
module sssd_datapath #(
  parameter int unsigned NUM_DIGITS = sssd_pkg::NumDigitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [sssd_pkg::ValueWidth-1:0] value_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_data_i,
  input  sssd_pkg::cmd_t                  cmd_i,
  output sssd_pkg::status_t               sts_o,
  output logic [7:0]                      digit_enable_o,
  output logic [7:0]                      segments_o,
  output logic [2:0]                      digit_position_o
);
  import sssd_pkg::*;

  localparam logic [2:0] LastPos  = 3'(NUM_DIGITS - 1);
  localparam logic [2:0] PosLimit = 3'(CodeDigits);

  logic [ValueWidth-1:0] cached_q;
  logic                  bcd_mode_q;
  logic [3:0]            digits_q [CodeDigits];
  logic [2:0]            scan_q;
  logic [BinBits-1:0]    shift_q;
  logic [ValueWidth-1:0] acc_q;
  logic [7:0]            digit_enable_q;
  logic [7:0]            segments_q;
  logic [2:0]            digit_position_q;

  logic [ValueWidth-1:0] sat_value;
  logic [ValueWidth-1:0] acc_adj;
  logic [ValueWidth-1:0] acc_step;
  logic [3:0]            bcd_codes [CodeDigits];
  logic [3:0]            dec_codes [CodeDigits];
  logic [7:0]            en_next;
  logic [7:0]            seg_next;
  logic [2:0]            scan_next;

  assign sts_o.changed  = (value_i != cached_q);
  assign sts_o.bcd_mode = bcd_mode_q;

  assign sat_value = (value_i > DecMax) ? DecMax : value_i;

  // one double-dabble step: fix each bcd digit then shift in the next bit
  always_comb begin
    for (int i = 0; i < CodeDigits; i++) begin
      if (acc_q[4*i +: 4] > 4'd4) begin
        acc_adj[4*i +: 4] = acc_q[4*i +: 4] + 4'd3;
      end else begin
        acc_adj[4*i +: 4] = acc_q[4*i +: 4];
      end
    end
    acc_step = {acc_adj[ValueWidth-2:0], shift_q[BinBits-1]};
  end

  // packed nibbles, leftmost digit in the top nibble
  always_comb begin
    for (int i = 0; i < CodeDigits; i++) begin
      bcd_codes[i] = value_i[ValueWidth-1-4*i -: 4];
      if (bcd_codes[i] > CodeMaxDec) begin
        bcd_codes[i] = CodeBlank;
      end
    end
  end

  // leading zero blanking on the converted decimal digits
  always_comb begin
    logic lead;
    lead = 1'b1;
    for (int i = 0; i < CodeDigits; i++) begin
      dec_codes[i] = acc_q[ValueWidth-1-4*i -: 4];
      if (lead && (dec_codes[i] == 4'd0)) begin
        dec_codes[i] = CodeBlank;
      end else begin
        lead = 1'b0;
      end
    end
  end

  always_comb begin
    en_next  = 8'h00;
    seg_next = SegBlank;
    if (scan_q < PosLimit) begin
      en_next  = 8'b0000_0100 << scan_q;
      seg_next = seg_lut(digits_q[scan_q]);
    end
    scan_next = (scan_q == LastPos) ? 3'd0 : scan_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_q   <= '0;
      bcd_mode_q <= 1'b0;
      scan_q     <= 3'd0;
      for (int i = 0; i < CodeDigits; i++) begin
        digits_q[i] <= 4'd0;
      end
    end else begin
      if (cfg_we_i) begin
        bcd_mode_q <= cfg_data_i;
      end
      if (cmd_i.load && sts_o.changed) begin
        cached_q <= value_i;
        if (bcd_mode_q) begin
          for (int i = 0; i < CodeDigits; i++) begin
            digits_q[i] <= bcd_codes[i];
          end
        end
      end
      if (cmd_i.commit) begin
        for (int i = 0; i < CodeDigits; i++) begin
          digits_q[i] <= dec_codes[i];
        end
      end
      if (cmd_i.emit) begin
        scan_q <= scan_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      shift_q <= sat_value[BinBits-1:0];
      acc_q   <= '0;
    end else if (cmd_i.step) begin
      shift_q <= {shift_q[BinBits-2:0], 1'b0};
      acc_q   <= acc_step;
    end
    if (cmd_i.emit) begin
      digit_enable_q   <= en_next;
      segments_q       <= seg_next;
      digit_position_q <= scan_q;
    end
  end

  assign digit_enable_o   = digit_enable_q;
  assign segments_o       = segments_q;
  assign digit_position_o = digit_position_q;

endmodule

>>> rtl/core/sssd_ctrl.sv
// ----------------------------------------------------------------------------
// sssd_ctrl
// sequencer: accept, convert and commit digit codes for a changed binary value, emit one result item
// ----------------------------------------------------------------------------
`include "seven_segment_scan_driver_assert.svh"

module sssd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sssd_pkg::status_t sts_i,
  output sssd_pkg::cmd_t    cmd_o
);
  import sssd_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StConv   = 4'b0010,
    StCommit = 4'b0100,
    StEmit   = 4'b1000
  } state_e;

  localparam logic [StepWidth-1:0] LastStep = StepWidth'(BinBits - 1);

  state_e               state_q, state_d;
  logic [StepWidth-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 emit;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  assign cmd_o.load   = accept;
  assign cmd_o.step   = (state_q == StConv);
  assign cmd_o.commit = (state_q == StCommit);
  assign cmd_o.emit   = emit;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (accept) begin
          // changed binary values need the iterative conversion
          if (sts_i.changed && !sts_i.bcd_mode) begin
            state_d = StConv;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StConv: begin
        cnt_d = cnt_q + StepWidth'(1);
        if (cnt_q == LastStep) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (emit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SSSD_ASSERT(a_rise_after_emit, $rose(out_valid_o) |-> $past(state_q == StEmit), "item shown without emit")
  `SSSD_ASSERT(a_conv_bound, (state_q == StConv) |-> (cnt_q <= LastStep), "conversion overran")
  `SSSD_ASSERT(a_bin_change_converts, (accept && sts_i.changed && !sts_i.bcd_mode) |=> (state_q == StConv), "changed binary value skipped conversion")
  `SSSD_ASSERT(a_commit_after_conv, (state_q == StCommit) |-> $past(state_q == StConv), "commit without conversion")

endmodule

>>> rtl/core/seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// six digit multiplexed seven-segment scan driver, binary or packed bcd input
// flow: an unchanged value or one in bcd mode goes from accept to emit; a
//   changed binary value first takes the conversion and commit states
// one item at a time: a new item is accepted only in idle; conversion is load,
//   20 shift-add-3 steps over the 20-bit saturated value and the commit
// reset: asynchronous, clears cached value, digit codes, scan position and mode
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
  parameter int unsigned NUM_DIGITS = sssd_pkg::NumDigitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sssd_pkg::ValueWidth-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      digit_enable_o,
  output logic [7:0]                      segments_o,
  output logic [2:0]                      digit_position_o
);
  import sssd_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // mode register always takes a write
  assign cfg_ready_o = 1'b1;

  sssd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sssd_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .value_i          (value_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .digit_enable_o   (digit_enable_o),
    .segments_o       (segments_o),
    .digit_position_o (digit_position_o)
  );

endmodule
